// File: hdl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants for the SQL tuple token parser
// Byte codes, parser phases, item structs and the token count cap.
// ----------------------------------------------------------------------------
package stp_pkg;

  // Token count limit; the count also never exceeds what 5 bits can carry
  localparam int unsigned MaxTokens = 16;
  localparam int unsigned TallyW    = 5;
  localparam logic [TallyW-1:0] TallyCap =
    TallyW'((MaxTokens < 31) ? MaxTokens : 31);

  // Byte codes
  localparam logic [7:0] ChOpen  = 8'h28;  // (
  localparam logic [7:0] ChClose = 8'h29;  // )
  localparam logic [7:0] ChComma = 8'h2C;  // ,
  localparam logic [7:0] ChQuote = 8'h27;  // '
  localparam logic [7:0] ChBsl   = 8'h5C;  // backslash

  typedef enum logic [2:0] {
    PhSeek   = 3'd0,
    PhStart  = 3'd1,
    PhUnq    = 3'd2,
    PhQuoted = 3'd3,
    PhEsc    = 3'd4,
    PhAfterq = 3'd5,
    PhStop   = 3'd6
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [TallyW-1:0]   tally;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              token_end;
    logic              tuple_end;
    logic [TallyW-1:0] tuple_tokens;
    logic              stream_stop;
  } out_item_t;

endpackage

// File: hdl/stp_step.sv
// ----------------------------------------------------------------------------
// stp_step: one-byte parser transition
// Combinational next phase, next token count and result for one byte.
// ----------------------------------------------------------------------------
module stp_step import stp_pkg::*; #(
  parameter int unsigned TokenLimit = MaxTokens
) (
  input  parse_state_t state_i,
  input  in_item_t     item_i,
  output parse_state_t state_o,
  output out_item_t    res_o,
  output logic         res_valid_o
);

  // count stops at the limit, and never passes what 5 bits can carry
  localparam logic [TallyW-1:0] TallyLimit =
    TallyW'((TokenLimit < 31) ? TokenLimit : 31);

  parse_state_t      nxt;
  logic [7:0]        b;
  logic [7:0]        ob;
  logic              v, te, tu, st;
  logic [TallyW-1:0] cnt;

  function automatic logic [TallyW-1:0] bump(input logic [TallyW-1:0] t);
    bump = (t < TallyLimit) ? t + TallyW'(1) : t;
  endfunction

  assign b = item_i.in_byte;

  always_comb begin
    nxt = state_i;
    ob  = '0;
    v   = 1'b0;
    te  = 1'b0;
    tu  = 1'b0;
    st  = 1'b0;
    cnt = '0;

    case (state_i.phase)
      PhStart: begin
        if (b == ChClose) begin
          if (state_i.tally == '0) begin
            st        = 1'b1;
            nxt.phase = PhStop;
          end else begin
            tu        = 1'b1;
            nxt.phase = PhSeek;
          end
        end else if (b == ChQuote) begin
          nxt.phase = PhQuoted;
        end else if (b == ChComma) begin
          // empty unquoted token: close the tuple early
          nxt.tally = bump(state_i.tally);
          te        = 1'b1;
          tu        = 1'b1;
          nxt.phase = PhSeek;
        end else begin
          ob        = b;
          v         = 1'b1;
          nxt.phase = PhUnq;
        end
      end
      PhUnq: begin
        if (b == ChComma) begin
          nxt.tally = bump(state_i.tally);
          te        = 1'b1;
          nxt.phase = PhStart;
        end else if (b == ChClose) begin
          nxt.tally = bump(state_i.tally);
          te        = 1'b1;
          tu        = 1'b1;
          nxt.phase = PhSeek;
        end else begin
          ob = b;
          v  = 1'b1;
        end
      end
      PhQuoted: begin
        if (b == ChQuote) begin
          nxt.tally = bump(state_i.tally);
          te        = 1'b1;
          nxt.phase = PhAfterq;
        end else if (b == ChBsl) begin
          nxt.phase = PhEsc;
        end else begin
          ob = b;
          v  = 1'b1;
        end
      end
      PhEsc: begin
        ob        = b;
        v         = 1'b1;
        nxt.phase = PhQuoted;
      end
      PhAfterq: begin
        if (b == ChComma) begin
          nxt.phase = PhStart;
        end else if (b == ChClose) begin
          tu        = 1'b1;
          nxt.phase = PhSeek;
        end else if (b == ChQuote) begin
          nxt.phase = PhQuoted;
        end else begin
          ob        = b;
          v         = 1'b1;
          nxt.phase = PhUnq;
        end
      end
      PhStop: begin
        nxt = state_i;
      end
      default: begin
        nxt.phase = PhSeek;
        if (b == ChOpen) begin
          nxt.phase = PhStart;
          nxt.tally = '0;
        end
      end
    endcase

    // end of stream: flush open token and tuple, then rearm unless the stream stops
    if (item_i.last_byte && (nxt.phase != PhStop)) begin
      case (nxt.phase)
        PhUnq, PhQuoted, PhEsc: begin
          nxt.tally = bump(nxt.tally);
          te        = 1'b1;
          tu        = 1'b1;
        end
        PhAfterq: begin
          tu = 1'b1;
        end
        PhStart: begin
          if (nxt.tally == '0) st = 1'b1;
          else tu = 1'b1;
        end
        default: begin
        end
      endcase
      cnt       = tu ? nxt.tally : '0;
      nxt.phase = st ? PhStop : PhSeek;
      nxt.tally = '0;
    end else begin
      cnt = tu ? nxt.tally : '0;
    end
  end

  assign state_o              = nxt;
  assign res_o.out_byte       = ob;
  assign res_o.byte_valid     = v;
  assign res_o.token_end      = te;
  assign res_o.tuple_end      = tu;
  assign res_o.tuple_tokens   = cnt;
  assign res_o.stream_stop    = st;
  assign res_valid_o          = v | te | tu | st;

endmodule

// File: hdl/sql_tuple_token_parser.sv
// Result path: input register, then result register.
// Throughput: 1 byte per cycle while the output is not stalled; the parser state loop is one short
//   combinational step between the input register and the result register.
// Bytes that produce no result are consumed without an output item.
// Reset (async, active low): pipeline empty, parser seeking '(' with zero count.
// ----------------------------------------------------------------------------
// sql_tuple_token_parser: SQL VALUES tuple tokenizer
// Splits parenthesized tuples from a byte stream into tokens, one byte/item.
// ----------------------------------------------------------------------------
module sql_tuple_token_parser import stp_pkg::*; #(
  parameter int unsigned TokenLimit = MaxTokens
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // effective count cap, same rule as in the step logic
  localparam logic [TallyW-1:0] TallyLimit =
    TallyW'((TokenLimit < 31) ? TokenLimit : 31);

  // input stage
  logic         s1_valid_q;
  in_item_t     s1_item_q;
  logic         s1_go;
  logic         in_fire;

  // parser state
  parse_state_t state_q, state_d;

  // step result
  out_item_t    res;
  logic         res_valid;

  // output stage
  logic         out_valid_q;
  out_item_t    out_item_q;
  logic         out_free;

  // Output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;
  // The staged byte moves on whenever the result slot can take it
  assign s1_go    = s1_valid_q && out_free;
  // Take a new byte while the staged one leaves, or when stage is empty
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  stp_step #(
    .TokenLimit (TokenLimit)
  ) u_step (
    .state_i     (state_q),
    .item_i      (s1_item_q),
    .state_o     (state_d),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  // Parser state advances once per byte, as the byte leaves stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhSeek, tally: '0};
    end else if (s1_go) begin
      state_q <= state_d;
    end
  end

  // Result register: loaded only for bytes that produce an item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_go && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // A stop never comes with a tuple end
  a_stop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.stream_stop && out_item_o.tuple_end))
    else $error("stream_stop together with tuple_end");

  // Count only shown with tuple end
  a_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.tuple_end) |-> (out_item_o.tuple_tokens == '0))
    else $error("tuple_tokens nonzero without tuple_end");

  // Stopped parser stays stopped until reset
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PhStop) |=> (state_q.phase == PhStop))
    else $error("parser left stop phase");

  // Token count never passes its cap
  a_tally_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tally <= TallyLimit)
    else $error("token count above cap");

  // A staged byte that cannot move must not be overwritten
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("stage 1 byte lost while stalled");
`endif

endmodule
